FILE: src/lmfs_pkg.sv
// shared constants, codes and types for the led matrix fade scanner
// no dependencies
package lmfs_pkg;

  localparam int LED_ROWS_DEF    = 4;
  localparam int LED_COLUMNS_DEF = 8;
  localparam int FADE_LEVELS_DEF = 64;

  localparam int OUT_ROWS = 4;
  localparam int STEP_W   = 6;
  localparam int LEVEL_W  = 8;
  localparam int COLOUT_W = 3;

  localparam logic [LEVEL_W-1:0] FULL_ON = 8'd255;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_LED   = 2'd1;
  localparam logic [1:0] FUNC_SCALE = 2'd2;

  localparam logic [1:0] CFG_FADE_STEP  = 2'd0;
  localparam logic [1:0] CFG_INVERT_PWM = 2'd1;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_ON  = 2'd1,
    MODE_PWM = 2'd2
  } mode_t;

  typedef struct packed {
    logic              tick_go;
    logic              wr_go;
    logic [STEP_W-1:0] fade_step;
    logic              invert_pwm;
  } lmfs_ctl_t;

endpackage

FILE: src/led_matrix_fade_scanner.sv
// led matrix column scanner with per-led fade, top level
// depends on lmfs_pkg and lmfs_row
// a scan tick passes s1 and s2 in order and its result is then registered at the output
// throughput: one request per cycle while results are taken; output back-pressure holds a tick in s1
// led writes take effect at acceptance, scale loads in the cycle after, in order with ticks
// reset clears config, the active column, the led states, the pipeline valids and the column and scale valid bits
module led_matrix_fade_scanner #(
  parameter int LED_ROWS    = lmfs_pkg::LED_ROWS_DEF,
  parameter int LED_COLUMNS = lmfs_pkg::LED_COLUMNS_DEF,
  parameter int FADE_LEVELS = lmfs_pkg::FADE_LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [4:0] in_led_index,
  input  logic       in_led_lit,
  input  logic [5:0] in_scale_index,
  input  logic [7:0] in_scale_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_column,
  output logic [1:0] out_row0_mode,
  output logic [7:0] out_row0_level,
  output logic [1:0] out_row1_mode,
  output logic [7:0] out_row1_level,
  output logic [1:0] out_row2_mode,
  output logic [7:0] out_row2_level,
  output logic [1:0] out_row3_mode,
  output logic [7:0] out_row3_level,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data
);
  import lmfs_pkg::*;

  localparam int NUM_LEDS = LED_ROWS * LED_COLUMNS;
  localparam int CNT_W    = $clog2(FADE_LEVELS);
  localparam int COL_W    = $clog2(LED_COLUMNS);
  localparam int LED_W    = $clog2(NUM_LEDS);
  localparam int SIDX_W   = (CNT_W > 6) ? CNT_W : 6;

  // config
  logic [STEP_W-1:0] fade_step_r;
  logic              invert_pwm_r;

  // state
  logic [COL_W-1:0]  active_column_r;
  logic              led_on_r [NUM_LEDS];
  logic              col_vld_r [LED_COLUMNS];
  logic [FADE_LEVELS-1:0] scl_vld_r;
  logic [LED_ROWS-1:0][CNT_W-1:0] cnt_mem [LED_COLUMNS];

  // pipeline
  logic                 s1_vld_r;
  logic                 s1_tick_r;
  logic [COL_W-1:0]     s1_col_r;
  logic [LED_ROWS-1:0]  s1_lit_r;
  logic                 s1_cvld_r;
  logic [LED_ROWS-1:0][CNT_W-1:0] s1_cnt_r;
  logic [CNT_W-1:0]     s1_waddr_r;
  logic [7:0]           s1_wdata_r;
  logic                 s2_vld_r;
  logic [COL_W-1:0]     s2_col_r;
  logic                 out_valid_r;
  logic [COLOUT_W-1:0]  out_column_r;
  mode_t                out_mode_r  [OUT_ROWS];
  logic [LEVEL_W-1:0]   out_level_r [OUT_ROWS];

  logic accept;
  logic is_tick;
  logic led_ok;
  logic scale_ok;
  logic s1_load;
  logic out_free;
  logic s2_free;
  logic s2_go;
  logic s1_go;
  logic [SIDX_W-1:0] sidx_ext;
  logic [LED_ROWS-1:0] lit_now;
  logic [LED_ROWS-1:0][CNT_W-1:0] cnt_eff;
  logic [LED_ROWS-1:0][CNT_W-1:0] cnt_wr;
  mode_t      row_mode  [OUT_ROWS];
  logic [7:0] row_level [OUT_ROWS];
  lmfs_ctl_t  ctl;

  assign out_free = !out_valid_r || out_ready;
  assign s2_free  = !s2_vld_r || out_free;
  assign s2_go    = s2_vld_r && out_free;
  assign s1_go    = s1_vld_r && (!s1_tick_r || s2_free);
  assign in_ready = !s1_vld_r || s1_go;
  assign accept   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign sidx_ext = SIDX_W'(in_scale_index);
  assign is_tick  = (in_func == FUNC_TICK);
  assign led_ok   = (in_func == FUNC_LED) && ({1'b0, in_led_index} < 6'(NUM_LEDS));
  assign scale_ok = (in_func == FUNC_SCALE) && (9'(in_scale_index) < 9'(FADE_LEVELS));
  assign s1_load  = accept && (is_tick || scale_ok);

  assign ctl.tick_go    = s1_go && s1_tick_r;
  assign ctl.wr_go      = s1_go && !s1_tick_r;
  assign ctl.fade_step  = fade_step_r;
  assign ctl.invert_pwm = invert_pwm_r;

  always_comb begin
    for (int r = 0; r < LED_ROWS; r++) begin
      lit_now[r] = led_on_r[LED_W'(r * LED_COLUMNS) + LED_W'(active_column_r)];
      cnt_eff[r] = s1_cvld_r ? s1_cnt_r[r] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_step_r  <= '0;
      invert_pwm_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FADE_STEP:  fade_step_r  <= cfg_data;
        CFG_INVERT_PWM: invert_pwm_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_column_r <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_on_r[i] <= 1'b0;
      end
    end else if (accept) begin
      if (led_ok) begin
        led_on_r[in_led_index[LED_W-1:0]] <= in_led_lit;
      end
      if (is_tick) begin
        active_column_r <= (active_column_r == COL_W'(LED_COLUMNS - 1)) ? '0 :
                           active_column_r + 1'b1;
      end
    end
  end

  // counter memory: read at tick acceptance, written back when the tick leaves s1;
  // consecutive ticks use different columns, so a read never overlaps a pending write
  always_ff @(posedge clk) begin
    if (accept && is_tick) begin
      s1_cnt_r <= cnt_mem[active_column_r];
    end
    if (ctl.tick_go) begin
      cnt_mem[s1_col_r] <= cnt_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < LED_COLUMNS; c++) begin
        col_vld_r[c] <= 1'b0;
      end
      scl_vld_r <= '0;
    end else begin
      if (ctl.tick_go) begin
        col_vld_r[s1_col_r] <= 1'b1;
      end
      if (ctl.wr_go) begin
        scl_vld_r[s1_waddr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= s1_load;
      end
      if (s2_free) begin
        s2_vld_r <= ctl.tick_go;
      end
      if (out_free) begin
        out_valid_r <= s2_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_tick_r  <= is_tick;
      s1_col_r   <= active_column_r;
      s1_lit_r   <= lit_now;
      s1_cvld_r  <= col_vld_r[active_column_r];
      s1_waddr_r <= sidx_ext[CNT_W-1:0];
      s1_wdata_r <= in_scale_value;
    end
    if (ctl.tick_go) begin
      s2_col_r <= s1_col_r;
    end
    if (s2_go) begin
      out_column_r <= COLOUT_W'(s2_col_r);
      for (int r = 0; r < OUT_ROWS; r++) begin
        out_mode_r[r]  <= row_mode[r];
        out_level_r[r] <= row_level[r];
      end
    end
  end

  for (genvar r = 0; r < OUT_ROWS; r++) begin : g_row
    if (r < LED_ROWS) begin : g_live
      lmfs_row #(
        .FADE_LEVELS (FADE_LEVELS),
        .CNT_W       (CNT_W)
      ) u_row (
        .clk     (clk),
        .ctl     (ctl),
        .wr_addr (s1_waddr_r),
        .wr_data (s1_wdata_r),
        .scl_vld (scl_vld_r),
        .lit     (s1_lit_r[r]),
        .cnt_cur (cnt_eff[r]),
        .cnt_nxt (cnt_wr[r]),
        .mode    (row_mode[r]),
        .level   (row_level[r])
      );
    end else begin : g_absent
      assign row_mode[r]  = MODE_OFF;
      assign row_level[r] = 8'd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_column     = out_column_r;
  assign out_row0_mode  = out_mode_r[0];
  assign out_row0_level = out_level_r[0];
  assign out_row1_mode  = out_mode_r[1];
  assign out_row1_level = out_level_r[1];
  assign out_row2_mode  = out_mode_r[2];
  assign out_row2_level = out_level_r[2];
  assign out_row3_mode  = out_mode_r[3];
  assign out_row3_level = out_level_r[3];

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({1'b0, out_column_r} < (COLOUT_W + 1)'(LED_COLUMNS)))
    else $error("result column out of range");

  a_go_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.tick_go && ctl.wr_go))
    else $error("tick and scale load leave s1 together");

  a_tick_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.tick_go |=> s2_vld_r)
    else $error("tick lost between s1 and s2");

  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_go |=> out_valid_r)
    else $error("tick lost between s2 and output");

endmodule

FILE: src/lmfs_row.sv
// one matrix row: counter update, its copy of the scale table and drive decode
// depends on lmfs_pkg
module lmfs_row #(
  parameter int FADE_LEVELS = lmfs_pkg::FADE_LEVELS_DEF,
  parameter int CNT_W       = $clog2(FADE_LEVELS)
) (
  input  logic                       clk,
  input  lmfs_pkg::lmfs_ctl_t        ctl,
  input  logic [CNT_W-1:0]           wr_addr,
  input  logic [7:0]                 wr_data,
  input  logic [FADE_LEVELS-1:0]     scl_vld,
  input  logic                       lit,
  input  logic [CNT_W-1:0]           cnt_cur,
  output logic [CNT_W-1:0]           cnt_nxt,
  output lmfs_pkg::mode_t            mode,
  output logic [7:0]                 level
);
  import lmfs_pkg::*;

  localparam int SUM_W = ((CNT_W > STEP_W) ? CNT_W : STEP_W) + 1;
  localparam logic [SUM_W-1:0] CNT_MAX = SUM_W'(FADE_LEVELS - 1);

  logic [7:0]       scl_mem [FADE_LEVELS];
  logic [7:0]       bright_r;
  logic             bvld_r;
  logic             force_r;
  logic             force_on;
  logic [SUM_W-1:0] cnt_ext;
  logic [SUM_W-1:0] step_ext;
  logic [SUM_W-1:0] sum;
  logic [7:0]       bright;

  assign force_on = (ctl.fade_step == '0) && lit;
  assign cnt_ext  = SUM_W'(cnt_cur);
  assign step_ext = SUM_W'(ctl.fade_step);
  assign sum      = cnt_ext + step_ext;

  always_comb begin
    if (force_on) begin
      cnt_nxt = cnt_cur;
    end else if (lit) begin
      cnt_nxt = (sum > CNT_MAX) ? CNT_MAX[CNT_W-1:0] : sum[CNT_W-1:0];
    end else if (cnt_ext > step_ext) begin
      cnt_nxt = CNT_W'(cnt_ext - step_ext);
    end else begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_go) begin
      scl_mem[wr_addr] <= wr_data;
    end
    if (ctl.tick_go) begin
      bright_r <= scl_mem[cnt_cur];
      bvld_r   <= scl_vld[cnt_cur];
      force_r  <= force_on;
    end
  end

  assign bright = bvld_r ? bright_r : 8'd0;

  always_comb begin
    mode  = MODE_OFF;
    level = 8'd0;
    if (force_r || bright == FULL_ON) begin
      mode = MODE_ON;
    end else if (bright != 8'd0) begin
      mode  = MODE_PWM;
      level = ctl.invert_pwm ? (FULL_ON - bright) : bright;
    end
  end

endmodule

FILE: tb/sv/lmfs_scan_checker.sv
// scoreboard for the led matrix fade scanner: tracks led, counter and scale state,
// predicts every scan result and compares it field by field
// depends on lmfs_pkg
`timescale 1ns / 100ps

module lmfs_scan_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [4:0] in_led_index,
  input  logic       in_led_lit,
  input  logic [5:0] in_scale_index,
  input  logic [7:0] in_scale_value,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_column,
  input  logic [1:0] out_row0_mode,
  input  logic [7:0] out_row0_level,
  input  logic [1:0] out_row1_mode,
  input  logic [7:0] out_row1_level,
  input  logic [1:0] out_row2_mode,
  input  logic [7:0] out_row2_level,
  input  logic [1:0] out_row3_mode,
  input  logic [7:0] out_row3_level,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_data,
  output int         errors,
  output int         pending,
  output int         scans_seen
);
  import lmfs_pkg::*;

  localparam int NUM_LEDS = LED_ROWS_DEF * LED_COLUMNS_DEF;

  typedef struct packed {
    logic [COLOUT_W-1:0]             column;
    logic [OUT_ROWS-1:0][1:0]         mode;
    logic [OUT_ROWS-1:0][LEVEL_W-1:0] level;
  } scan_result_t;

  logic [STEP_W-1:0]   fade_step;
  logic                invert_pwm;
  logic [COLOUT_W-1:0] cur_col;
  logic                led_lit [NUM_LEDS];
  logic [5:0]          fade_cnt [NUM_LEDS];
  logic [LEVEL_W-1:0]  scale_tab [FADE_LEVELS_DEF];

  scan_result_t expected_scans [$];

  logic [OUT_ROWS-1:0][1:0]         got_mode;
  logic [OUT_ROWS-1:0][LEVEL_W-1:0] got_level;

  assign got_mode  = {out_row3_mode, out_row2_mode, out_row1_mode, out_row0_mode};
  assign got_level = {out_row3_level, out_row2_level, out_row1_level, out_row0_level};

  // drive of the active column, then counters step toward their targets
  function automatic scan_result_t scan_column();
    scan_result_t r;
    int unsigned  idx;
    logic [6:0]   c;
    logic [6:0]   tgt;
    logic [7:0]   b;
    r = '0;
    r.column = cur_col;
    for (int row = 0; row < OUT_ROWS; row++) begin
      if (row < LED_ROWS_DEF) begin
        idx = cur_col + row * LED_COLUMNS_DEF;
        tgt = led_lit[idx] ? 7'(FADE_LEVELS_DEF - 1) : 7'd0;
        c   = {1'b0, fade_cnt[idx]};
        if (fade_step == '0 && tgt != 7'd0) begin
          r.mode[row] = MODE_ON;
        end else begin
          b = scale_tab[c[5:0]];
          if (b == FULL_ON) begin
            r.mode[row] = MODE_ON;
          end else if (b != 8'd0) begin
            r.mode[row]  = MODE_PWM;
            r.level[row] = invert_pwm ? (FULL_ON - b) : b;
          end
          if (c < tgt) begin
            c = c + {1'b0, fade_step};
            if (c > tgt) c = tgt;
          end else if (c > tgt) begin
            c = (c > {1'b0, fade_step}) ? (c - {1'b0, fade_step}) : 7'd0;
          end
          fade_cnt[idx] = c[5:0];
        end
      end
    end
    cur_col = (cur_col == COLOUT_W'(LED_COLUMNS_DEF - 1)) ? '0 : cur_col + 1'b1;
    return r;
  endfunction

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("lmfs_scan_checker: scan %0d %s expected %0d got %0d",
                 scans_seen, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst_n) begin
      fade_step  = '0;
      invert_pwm = 1'b0;
      cur_col    = '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_lit[i]  = 1'b0;
        fade_cnt[i] = '0;
      end
      for (int i = 0; i < FADE_LEVELS_DEF; i++) scale_tab[i] = '0;
      expected_scans.delete();
      errors     = 0;
      scans_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FADE_STEP) fade_step = cfg_data;
        else if (cfg_index == CFG_INVERT_PWM) invert_pwm = cfg_data[0];
      end
      if (out_valid && out_ready) begin
        if (expected_scans.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("lmfs_scan_checker: unexpected scan result, column %0d", out_column);
        end else begin
          want = expected_scans.pop_front();
          report_field("column", 8'(want.column), 8'(out_column));
          for (int row = 0; row < OUT_ROWS; row++) begin
            report_field($sformatf("row%0d_mode", row), 8'(want.mode[row]),
                         8'(got_mode[row]));
            report_field($sformatf("row%0d_level", row), want.level[row], got_level[row]);
          end
        end
        scans_seen++;
      end
      if (in_valid && in_ready) begin
        if (in_func == FUNC_TICK) expected_scans.push_back(scan_column());
        else if (in_func == FUNC_LED) led_lit[in_led_index] = in_led_lit;
        else if (in_func == FUNC_SCALE) scale_tab[in_scale_index] = in_scale_value;
      end
    end
    pending = expected_scans.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
// testbench top for the led matrix fade scanner: clock, reset, request and
// register stimulus, result back-pressure and the verdict
// depends on lmfs_pkg, led_matrix_fade_scanner and lmfs_scan_checker
`timescale 1ns / 100ps

module tb_top;
  import lmfs_pkg::*;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 120;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_func;
  logic [4:0] in_led_index;
  logic       in_led_lit;
  logic [5:0] in_scale_index;
  logic [7:0] in_scale_value;
  logic       out_valid;
  logic       out_ready;
  logic [2:0] out_column;
  logic [1:0] out_row0_mode;
  logic [7:0] out_row0_level;
  logic [1:0] out_row1_mode;
  logic [7:0] out_row1_level;
  logic [1:0] out_row2_mode;
  logic [7:0] out_row2_level;
  logic [1:0] out_row3_mode;
  logic [7:0] out_row3_level;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [5:0] cfg_data;

  int   errors;
  int   pending;
  int   scans_seen;
  int   reqs_sent;
  int   cfg_writes;
  logic burst;

  led_matrix_fade_scanner u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_led_index  (in_led_index),
    .in_led_lit    (in_led_lit),
    .in_scale_index(in_scale_index),
    .in_scale_value(in_scale_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_column    (out_column),
    .out_row0_mode (out_row0_mode),
    .out_row0_level(out_row0_level),
    .out_row1_mode (out_row1_mode),
    .out_row1_level(out_row1_level),
    .out_row2_mode (out_row2_mode),
    .out_row2_level(out_row2_level),
    .out_row3_mode (out_row3_mode),
    .out_row3_level(out_row3_level),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  lmfs_scan_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_led_index  (in_led_index),
    .in_led_lit    (in_led_lit),
    .in_scale_index(in_scale_index),
    .in_scale_value(in_scale_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_column    (out_column),
    .out_row0_mode (out_row0_mode),
    .out_row0_level(out_row0_level),
    .out_row1_mode (out_row1_mode),
    .out_row1_level(out_row1_level),
    .out_row2_mode (out_row2_mode),
    .out_row2_level(out_row2_level),
    .out_row3_mode (out_row3_mode),
    .out_row3_level(out_row3_level),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .scans_seen    (scans_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_top: timeout with %0d scan results outstanding", pending);
    $display("tb_top: done, errors");
    $finish;
  end

  // result side back-pressure
  initial begin : result_sink
    int unsigned n;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      n = burst ? 0 : $urandom_range(0, 16);
      if (n != 0) begin
        out_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  task automatic send_req(input logic [1:0] f, input logic [4:0] led_idx,
                          input logic lit, input logic [5:0] sidx,
                          input logic [7:0] sval);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func        = f;
    in_led_index   = led_idx;
    in_led_lit     = lit;
    in_scale_index = sidx;
    in_scale_value = sval;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    reqs_sent++;
  endtask

  // drop valid, wait for every scan result plus the pipeline tail
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [5:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_writes++;
  endtask

  function automatic logic [7:0] pick_brightness();
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'd0;
    if (r == 1) return FULL_ON;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_item();
    int unsigned r;
    logic [1:0]  f;
    r = $urandom_range(0, 99);
    if (r < 70) f = FUNC_TICK;
    else if (r < 85) f = FUNC_LED;
    else if (r < 95) f = FUNC_SCALE;
    else f = FUNC_UNUSED;
    send_req(f, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
             6'($urandom_range(0, 63)), pick_brightness());
  endtask

  initial begin : stimulus
    logic [5:0] step;
    logic [5:0] inv_word;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_TICK;
    in_led_index   = '0;
    in_led_lit     = 1'b0;
    in_scale_index = '0;
    in_scale_value = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_FADE_STEP;
    cfg_data       = '0;
    burst          = 1'b0;
    reqs_sent      = 0;
    cfg_writes     = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset state, table extremes, lit leds with fading off
    send_req(FUNC_TICK, 5'd0, 1'b0, 6'd0, 8'd0);
    send_req(FUNC_SCALE, 5'd0, 1'b0, 6'd63, FULL_ON);
    send_req(FUNC_SCALE, 5'd0, 1'b0, 6'd1, 8'd1);
    send_req(FUNC_SCALE, 5'd0, 1'b0, 6'd62, 8'd254);
    send_req(FUNC_SCALE, 5'd31, 1'b1, 6'd0, 8'd0);
    send_req(FUNC_LED, 5'd0, 1'b1, 6'd0, 8'd0);
    send_req(FUNC_LED, 5'd8, 1'b1, 6'd0, 8'd0);
    send_req(FUNC_LED, 5'd31, 1'b1, 6'd63, 8'd255);
    send_req(FUNC_UNUSED, 5'd31, 1'b1, 6'd63, 8'd255);
    repeat (8) send_req(FUNC_TICK, 5'd0, 1'b0, 6'd0, 8'd0);
    settle();
    // directed: largest step with inversion, counters jump straight to the target
    write_reg(CFG_FADE_STEP, 6'd63);
    write_reg(CFG_INVERT_PWM, 6'd1);
    repeat (8) send_req(FUNC_TICK, 5'd31, 1'b1, 6'd63, 8'd255);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      case (phase)
        0: begin step = 6'd1;  inv_word = 6'd0; end
        1: begin step = 6'd63; inv_word = 6'd1; end
        2: begin step = 6'd0;  inv_word = 6'd63; end
        3: begin step = 6'($urandom_range(1, 62)); inv_word = 6'd62; end
        4: begin step = 6'd2;  inv_word = 6'($urandom_range(0, 63)); end
        5: begin step = 6'd63; inv_word = 6'd0; end
        default: begin
          step     = 6'($urandom_range(0, 63));
          inv_word = 6'($urandom_range(0, 63));
        end
      endcase
      write_reg(CFG_FADE_STEP, step);
      write_reg(CFG_INVERT_PWM, inv_word);
      if (phase == 4) write_reg(CFG_UNUSED, 6'($urandom_range(0, 63)));
      burst = (phase == 2 || phase == 5);
      if (phase == 0)
        for (int i = 0; i < FADE_LEVELS_DEF; i++)
          send_req(FUNC_SCALE, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                   6'(i), pick_brightness());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 3 && i == PHASE_ITEMS / 2) settle();
        send_random_item();
      end
    end

    settle();
    $display("tb_top: %0d requests under %0d register writes, %0d scan results compared",
             reqs_sent, cfg_writes, scans_seen);
    $display("tb_top: fade steps 0 to 63, both pwm polarities, gaps and stalls 0 to 16");
    if (errors == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: %0d mismatches, %0d scan results missing", errors, pending);
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/lmfs_pkg.sv
src/lmfs_row.sv
src/led_matrix_fade_scanner.sv
tb/sv/lmfs_scan_checker.sv
tb/sv/tb_top.sv
